/* src/tccs_pkg.sv */
// Shared types and codes for the text console cursor/scroll unit.
package tccs_pkg;

    // Operation codes
    localparam logic [1:0] OP_PUT  = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Character codes
    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;

    // One request
    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [10:0] position;
    } in_item_t;

    // One result
    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [7:0]  cell_char;
        logic        scrolled;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;       // capture request, clear scroll flag
        logic put_step;     // write one byte at cursor and advance
        logic newline;      // move cursor to next row start
        logic set_start;    // load saturated position as cursor and operand
        logic mod_step;     // register reciprocal-multiply quotients
        logic mod_fin1;     // store column and tab phase
        logic mod2_start;   // load row start as remainder operand
        logic mod_fin2;     // store row-start tab phase
        logic read_issue;   // read addressed cell
        logic sweep_start;  // start a scroll sweep
        logic sweep_step;   // one sweep cell
        logic scroll_done;  // cursor to last row, flag scroll
        logic out_load;     // load output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       is_nul;
        logic       is_nl;
        logic       is_tab;
        logic       nl_end;      // newline reaches screen end
        logic       step_end;    // advance reaches screen end
        logic       phase_wrap;  // advance reaches a tab stop
        logic       sweep_end;
        logic       out_free;
    } sts_t;

endpackage

/* src/tccs_if.sv */
// Request and result channel interfaces.
interface tccs_in_if;
    logic                valid;
    logic                ready;
    tccs_pkg::in_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface tccs_out_if;
    logic                valid;
    logic                ready;
    tccs_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

/* src/tccs_ctrl.sv */
// Controller state machine of the text console unit.
module tccs_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output tccs_pkg::cmd_t cmd,
    input  tccs_pkg::sts_t sts
);
    import tccs_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_PUT    = 4'd3;
    localparam logic [3:0] S_MOD1   = 4'd4;
    localparam logic [3:0] S_MOD2S  = 4'd5;
    localparam logic [3:0] S_MOD2   = 4'd6;
    localparam logic [3:0] S_RDWAIT = 4'd7;
    localparam logic [3:0] S_SCROLL = 4'd8;
    localparam logic [3:0] S_FINISH = 4'd9;
    localparam logic [3:0] S_MOD3   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (sts.op)
                    OP_PUT:
                    begin
                        if (sts.is_nul)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (sts.is_nl)
                        begin
                            if (sts.nl_end)
                            begin
                                cmd.sweep_start = 1'b1;
                                state_next      = S_SCROLL;
                            end
                            else
                            begin
                                cmd.newline = 1'b1;
                                state_next  = S_FINISH;
                            end
                        end
                        else
                        begin
                            state_next = S_PUT;
                        end
                    end
                    OP_SET:
                    begin
                        cmd.set_start = 1'b1;
                        state_next    = S_MOD1;
                    end
                    OP_READ:
                    begin
                        cmd.read_issue = 1'b1;
                        state_next     = S_RDWAIT;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_PUT:
            begin
                cmd.put_step = 1'b1;
                if (sts.step_end)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_SCROLL;
                end
                else if (!sts.is_tab || sts.phase_wrap)
                begin
                    state_next = S_FINISH;
                end
            end
            // Quotients of the cursor
            S_MOD1:
            begin
                cmd.mod_step = 1'b1;
                state_next   = S_MOD2S;
            end
            // Column and phase; row start becomes the operand
            S_MOD2S:
            begin
                cmd.mod_fin1   = 1'b1;
                cmd.mod2_start = 1'b1;
                state_next     = S_MOD2;
            end
            // Quotient of the row start
            S_MOD2:
            begin
                cmd.mod_step = 1'b1;
                state_next   = S_MOD3;
            end
            S_MOD3:
            begin
                cmd.mod_fin2 = 1'b1;
                state_next   = S_FINISH;
            end
            S_RDWAIT:
            begin
                state_next = S_FINISH;
            end
            S_SCROLL:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_end)
                begin
                    cmd.scroll_done = 1'b1;
                    state_next      = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* src/tccs_dp.sv */
// Datapath: screen memory, cursor tracking, remainder unit, output register.
module tccs_dp #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tccs_pkg::in_item_t  in_item,
    input  tccs_pkg::cmd_t      cmd,
    output tccs_pkg::sts_t      sts,
    output logic                out_valid,
    input  logic                out_ready,
    output tccs_pkg::out_item_t out_item
);
    import tccs_pkg::*;

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int LRS        = COLUMNS * (ROWS - 1);
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CW         = $clog2(CELL_COUNT + 1);
    localparam int COLW       = $clog2(COLUMNS + 1);
    localparam int RTW        = $clog2(2 * TAB_WIDTH) + 1;
    localparam int CM         = COLUMNS % TAB_WIDTH;
    localparam int LRS_PH     = LRS % TAB_WIDTH;
    // Reciprocals, exact for every operand below 2**CW
    localparam int QW         = 2 * CW + 2;
    localparam int C_SH       = CW + $clog2(COLUMNS);
    localparam int C_MUL      = ((1 << C_SH) + COLUMNS - 1) / COLUMNS;
    localparam int T_SH       = CW + $clog2(TAB_WIDTH);
    localparam int T_MUL      = ((1 << T_SH) + TAB_WIDTH - 1) / TAB_WIDTH;

    // Screen memory
    logic [7:0] mem [CELL_COUNT];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [7:0]    mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;
    logic [7:0]    rdata_reg;

    // Request and cursor state
    logic [1:0]      op_reg;
    logic [7:0]      chr_reg;
    logic [10:0]     pos_reg;
    logic [CW-1:0]   cursor_reg;
    logic [COLW-1:0] col_reg;
    logic [RTW-1:0]  phase_reg;
    logic [RTW-1:0]  rowph_reg;
    logic            scrolled_reg;

    // Sweep and remainder unit
    logic [CW-1:0]   sweep_reg;
    logic            clr_mode_reg;
    logic [CW-1:0]   shift_reg;
    logic [CW-1:0]   qc_reg;
    logic [CW-1:0]   qt_reg;

    logic            out_valid_reg;
    out_item_t       out_item_reg;

    logic            pos_ok;
    logic [CW-1:0]   pos_sat;
    logic [CW-1:0]   pos_inc;
    logic [COLW-1:0] col_inc;
    logic [RTW-1:0]  phase_inc;
    logic [RTW-1:0]  rowph_adv;
    logic [CW-1:0]   nl_pos;
    logic [CW-1:0]   sweep_m1;
    logic [QW-1:0]   qc_prod;
    logic [QW-1:0]   qt_prod;
    logic [CW-1:0]   row_base;
    logic [CW-1:0]   tab_base;
    logic [CW-1:0]   col_rem;
    logic [CW-1:0]   tab_rem;
    logic            col_wrap;
    logic            ph_wrap;
    logic            sweep_rd;

    // Combinational helpers
    always_comb
    begin
        pos_ok    = (32'(pos_reg) < 32'(CELL_COUNT));
        pos_sat   = pos_ok ? CW'(pos_reg) : CW'(CELL_COUNT - 1);
        pos_inc   = cursor_reg + CW'(1);
        col_inc   = col_reg + COLW'(1);
        col_wrap  = (col_inc == COLW'(COLUMNS));
        phase_inc = phase_reg + RTW'(1);
        ph_wrap   = (phase_inc == RTW'(TAB_WIDTH));
        rowph_adv = rowph_reg + RTW'(CM);
        if (rowph_adv >= RTW'(TAB_WIDTH))
        begin
            rowph_adv = rowph_adv - RTW'(TAB_WIDTH);
        end
        nl_pos    = cursor_reg - CW'(col_reg) + CW'(COLUMNS);
        sweep_m1  = sweep_reg - CW'(1);
        // quotient by reciprocal multiply, remainder by multiply-back
        qc_prod   = QW'(shift_reg) * QW'(C_MUL);
        qt_prod   = QW'(shift_reg) * QW'(T_MUL);
        row_base  = qc_reg * CW'(COLUMNS);
        tab_base  = qt_reg * CW'(TAB_WIDTH);
        col_rem   = shift_reg - row_base;
        tab_rem   = shift_reg - tab_base;
        sweep_rd  = cmd.sweep_step && !clr_mode_reg && (sweep_reg < CW'(LRS));
    end

    // Memory port selection: put writes at cursor, sweep writes one cell behind
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cursor_reg[AW-1:0];
        mem_wd = (chr_reg == CH_TAB) ? CH_SPACE : chr_reg;
        if (cmd.put_step)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.sweep_step && (sweep_reg != '0))
        begin
            mem_we = 1'b1;
            mem_wa = sweep_m1[AW-1:0];
            mem_wd = (clr_mode_reg || (sweep_m1 >= CW'(LRS))) ? 8'd0 : rdata_reg;
        end
        mem_re = 1'b0;
        mem_ra = pos_reg[AW-1:0];
        if (cmd.read_issue)
        begin
            mem_re = pos_ok;
        end
        else if (sweep_rd)
        begin
            mem_re = 1'b1;
            mem_ra = AW'(sweep_reg + CW'(COLUMNS));
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    // Captured request and remainder unit
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_item.op;
            chr_reg <= in_item.char_code;
            pos_reg <= in_item.position;
        end
        if (cmd.set_start)
        begin
            shift_reg <= pos_sat;
        end
        else if (cmd.mod2_start)
        begin
            shift_reg <= row_base;
        end
        if (cmd.mod_step)
        begin
            qc_reg <= CW'(qc_prod >> C_SH);
            qt_reg <= CW'(qt_prod >> T_SH);
        end
        if (cmd.out_load)
        begin
            out_item_reg.cursor_pos <= 11'(cursor_reg);
            out_item_reg.cell_char  <= ((op_reg == OP_READ) && pos_ok) ? rdata_reg : 8'd0;
            out_item_reg.scrolled   <= scrolled_reg;
        end
    end

    // Cursor, sweep and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg    <= '0;
            col_reg       <= '0;
            phase_reg     <= '0;
            rowph_reg     <= '0;
            scrolled_reg  <= 1'b0;
            sweep_reg     <= '0;
            clr_mode_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                scrolled_reg <= 1'b0;
            end
            if (cmd.put_step)
            begin
                cursor_reg <= pos_inc;
                phase_reg  <= ph_wrap ? '0 : phase_inc;
                if (col_wrap)
                begin
                    col_reg   <= '0;
                    rowph_reg <= rowph_adv;
                end
                else
                begin
                    col_reg <= col_inc;
                end
            end
            if (cmd.newline)
            begin
                cursor_reg <= nl_pos;
                col_reg    <= '0;
                rowph_reg  <= rowph_adv;
                phase_reg  <= rowph_adv;
            end
            if (cmd.set_start)
            begin
                cursor_reg <= pos_sat;
            end
            if (cmd.mod_fin1)
            begin
                col_reg   <= COLW'(col_rem);
                phase_reg <= RTW'(tab_rem);
            end
            if (cmd.mod_fin2)
            begin
                rowph_reg <= RTW'(tab_rem);
            end
            if (cmd.sweep_start)
            begin
                sweep_reg    <= '0;
                clr_mode_reg <= 1'b0;
            end
            else if (cmd.sweep_step)
            begin
                sweep_reg <= sweep_reg + CW'(1);
            end
            if (cmd.scroll_done)
            begin
                cursor_reg   <= CW'(LRS);
                col_reg      <= '0;
                phase_reg    <= RTW'(LRS_PH);
                rowph_reg    <= RTW'(LRS_PH);
                scrolled_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        sts.op         = op_reg;
        sts.is_nul     = (chr_reg == CH_NUL);
        sts.is_nl      = (chr_reg == CH_NL);
        sts.is_tab     = (chr_reg == CH_TAB);
        sts.nl_end     = (nl_pos == CW'(CELL_COUNT));
        sts.step_end   = (pos_inc == CW'(CELL_COUNT));
        sts.phase_wrap = ph_wrap;
        sts.sweep_end  = (sweep_reg == CW'(CELL_COUNT));
        sts.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

/* src/text_console_cursor_scroll_unit.sv */
// Text console engine: screen memory with linear cursor, newline, tab and scroll.
//
// Channels: in_ch carries requests (op, char_code, position), out_ch carries
// one result per request (cursor_pos, cell_char, scrolled). A request moves on a
// rising edge with valid and ready both high.
// One request at a time, from acceptance to result valid:
//   put of NUL, newline and unused op go from decode to the result; read
//   cell waits for the memory read; an ordinary byte writes one cell; tab
//   writes spaces up to the next tab stop (1 to TAB_WIDTH); set cursor
//   runs reciprocal-multiply remainders for the column, the tab phase and
//   the tab phase of the row start; any put that passes the last cell adds a
//   scroll sweep over every cell through the single write port of the memory.
// Reset: cursor goes to cell 0 and a clearing pass zeroes the screen;
// in_ch.ready stays low until it ends.
// A result sits in an output register; the next request is accepted while it
// waits, and that request holds in its last step until out_ch.ready frees the
// register.
module text_console_cursor_scroll_unit #(
    parameter int COLUMNS   = 80,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    tccs_in_if.sink   in_ch,
    tccs_out_if.source out_ch
);
    import tccs_pkg::*;

    cmd_t cmd;
    sts_t sts;

    tccs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tccs_dp #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_ch.item),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_item  (out_ch.item)
    );

    // One write source for the screen memory at a time
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.put_step, cmd.sweep_step}))
        else $error("put and sweep write in the same cycle");

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("output register loaded while full");

    // One request in flight: busy right after an acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request accepted while busy");

    // A scroll sweep ends the request: the result loads next unless the output register is full
    a_scroll_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scroll_done |=> (cmd.out_load || !sts.out_free))
        else $error("scroll not followed by result");

endmodule

/* tb/sv/text_console_cursor_scroll_unit_test.sv */
// Self-checking testbench for the text console cursor/scroll unit.
`timescale 1ns / 1ps

module text_console_cursor_scroll_unit_test;

    import tccs_pkg::*;

    localparam int COLUMNS        = 80;
    localparam int ROWS           = 25;
    localparam int TAB_WIDTH      = 4;
    localparam int CELLS          = COLUMNS * ROWS;
    localparam int LAST_ROW_START = COLUMNS * (ROWS - 1);

    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF       = 4;
    localparam int CLK_PERIOD     = 2 * CLK_HALF;
    localparam int RESET_CYCLES   = 10;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int QUEUE_DEPTH    = 16;
    localparam int SETTLE_CYCLES  = 64;
    // Budget: every request scrolling, plus margin for the longest gaps, four times over
    localparam longint unsigned TIMEOUT_CYCLES = 4 * (RANDOM_ITEMS + 200) * (CELLS + 100);

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // Testbench-owned drivers of the channel signals, known from time zero
    logic     req_valid = 1'b0;
    in_item_t req_item  = '0;
    logic     res_ready = 1'b0;

    tccs_in_if  req_if ();
    tccs_out_if res_if ();

    assign req_if.valid = req_valid;
    assign req_if.item  = req_item;
    assign res_if.ready = res_ready;

    text_console_cursor_scroll_unit #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_if),
        .out_ch (res_if)
    );

    // Mirror of the screen and cursor
    logic [7:0]  screen_mirror [CELLS];
    int unsigned cursor_mirror;

    in_item_t    pending_requests [$];
    out_item_t   console_results [$];

    int unsigned queued_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned checked_count  = 0;
    int unsigned fail_count     = 0;
    int unsigned put_count      = 0;
    int unsigned set_count      = 0;
    int unsigned read_count     = 0;
    int unsigned other_count    = 0;
    int unsigned scroll_count   = 0;

    int unsigned send_gap   = 0;
    int unsigned hold_left  = 0;
    bit          send_calm  = 1'b0;
    bit          sink_calm  = 1'b0;
    out_item_t   want;
    out_item_t   got;

    always #CLK_HALF clk = ~clk;

    // Gap length: mostly none or short, now and then long
    function automatic int unsigned pick_pause(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 75)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Console text: mostly printable, some high bytes, tabs, newlines and NUL
    function automatic logic [7:0] pick_text_char();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 8'($urandom_range(32, 126));
        if (r < 78)
            return 8'($urandom_range(128, 255));
        if (r < 85)
            return CH_TAB;
        if (r < 91)
            return CH_NL;
        if (r < 95)
            return CH_NUL;
        return 8'($urandom_range(0, 255));
    endfunction

    // Apply one accepted request to the mirror and queue the result it gives
    function automatic void predict_console(in_item_t req);
        out_item_t   res;
        int unsigned pos;
        int unsigned fill;
        int unsigned k;
        res = '0;
        case (req.op)
            OP_PUT:
            begin
                if (req.char_code != CH_NUL)
                begin
                    pos = cursor_mirror;
                    if (req.char_code == CH_NL)
                    begin
                        pos = (pos / COLUMNS + 1) * COLUMNS;
                    end
                    else if (req.char_code == CH_TAB)
                    begin
                        // spaces up to the next tab stop; none past the screen end
                        fill = TAB_WIDTH - (pos % TAB_WIDTH);
                        repeat (fill)
                        begin
                            if (pos < CELLS)
                                screen_mirror[pos] = CH_SPACE;
                            pos++;
                        end
                    end
                    else
                    begin
                        if (pos < CELLS)
                            screen_mirror[pos] = req.char_code;
                        pos++;
                    end
                    if (pos >= CELLS)
                    begin
                        // scroll up one row, clear the bottom row
                        for (k = 0; k < LAST_ROW_START; k++)
                            screen_mirror[k] = screen_mirror[k + COLUMNS];
                        for (k = LAST_ROW_START; k < CELLS; k++)
                            screen_mirror[k] = 8'h00;
                        cursor_mirror = LAST_ROW_START;
                        res.scrolled  = 1'b1;
                    end
                    else
                    begin
                        cursor_mirror = pos;
                    end
                end
            end
            OP_SET:
            begin
                cursor_mirror = (req.position < CELLS) ? req.position : CELLS - 1;
            end
            OP_READ:
            begin
                if (req.position < CELLS)
                    res.cell_char = screen_mirror[req.position];
            end
            default:
            begin
            end
        endcase
        res.cursor_pos = 11'(cursor_mirror);
        console_results.push_back(res);
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [7:0] ch,
                                input int unsigned pos);
        in_item_t req;
        while (pending_requests.size() >= QUEUE_DEPTH)
            @(posedge clk);
        req.op        = op;
        req.char_code = ch;
        req.position  = 11'(pos);
        pending_requests.push_back(req);
        queued_count++;
    endtask

    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || accepted_count != queued_count ||
               console_results.size() != 0)
            @(posedge clk);
    endtask

    // Request driver: one request per handshake, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            if (req_valid && req_if.ready)
            begin
                predict_console(req_item);
                accepted_count++;
                case (req_item.op)
                    OP_PUT:  put_count++;
                    OP_SET:  set_count++;
                    OP_READ: read_count++;
                    default: other_count++;
                endcase
                if ($urandom_range(0, 99) == 0)
                    send_calm = !send_calm;
            end
            if (!req_valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_valid <= 1'b0;
                end
                else if (pending_requests.size() != 0)
                begin
                    req_item  <= pending_requests.pop_front();
                    req_valid <= 1'b1;
                    send_gap  = pick_pause(send_calm);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: random back-pressure, compare against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_ready)
            begin
                got = res_if.item;
                if (console_results.size() == 0)
                begin
                    $error("unexpected result: cursor_pos %0d cell_char %0d scrolled %0d",
                           got.cursor_pos, got.cell_char, got.scrolled);
                    fail_count++;
                end
                else
                begin
                    want = console_results.pop_front();
                    checked_count++;
                    if (got.scrolled === 1'b1)
                        scroll_count++;
                    if (got.cursor_pos !== want.cursor_pos)
                    begin
                        $error("cursor_pos: expected %0d, actual %0d",
                               want.cursor_pos, got.cursor_pos);
                        fail_count++;
                    end
                    if (got.cell_char !== want.cell_char)
                    begin
                        $error("cell_char: expected %0d, actual %0d",
                               want.cell_char, got.cell_char);
                        fail_count++;
                    end
                    if (got.scrolled !== want.scrolled)
                    begin
                        $error("scrolled: expected %0d, actual %0d",
                               want.scrolled, got.scrolled);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                hold_left = pick_pause(sink_calm);
                if ($urandom_range(0, 299) == 0)
                    sink_calm = !sink_calm;
            end
        end
    end

    // Stimulus: reset, directed cases, then random bursts
    initial
    begin
        int unsigned k;
        int unsigned r;
        int unsigned n;
        int unsigned start;
        logic [7:0]  ch;
        bit          seen_nl;

        for (k = 0; k < CELLS; k++)
            screen_mirror[k] = 8'h00;
        cursor_mirror = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset contents, each put kind, saturation, scrolls, ranges
        send_request(OP_READ, 8'h00, 0);
        send_request(OP_PUT, 8'h41, 0);
        send_request(OP_PUT, CH_NUL, 11'h7ff);
        send_request(OP_PUT, CH_TAB, 0);
        send_request(OP_PUT, CH_NL, 0);
        send_request(OP_PUT, 8'hff, 0);
        send_request(OP_PUT, 8'h01, 0);
        send_request(OP_READ, 8'hff, 0);
        send_request(OP_SET, 8'h00, 11'h7ff);
        send_request(OP_PUT, 8'h5a, 0);
        send_request(OP_READ, 8'h00, CELLS - COLUMNS - 1);
        send_request(OP_READ, 8'h00, CELLS - 1);
        send_request(OP_READ, 8'h00, 11'h7ff);
        send_request(OP_READ, 8'h00, CELLS);
        send_request(OP_UNUSED, 8'hff, 11'h7ff);
        send_request(OP_SET, 8'h00, CELLS - 2);
        send_request(OP_PUT, CH_TAB, 0);
        send_request(OP_SET, 8'h00, CELLS - 1);
        send_request(OP_PUT, CH_TAB, 0);
        send_request(OP_SET, 8'h00, LAST_ROW_START);
        send_request(OP_PUT, CH_NL, 0);
        send_request(OP_SET, 8'h00, CELLS);
        send_request(OP_SET, 8'h00, 0);
        send_request(OP_PUT, 8'h80, 0);
        send_request(OP_READ, 8'h00, LAST_ROW_START - 1);

        // Hold off until every directed result is back
        wait_until_idle();

        while (queued_count < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 62)
            begin
                // Short text run in the upper rows; at most one newline, so no scroll
                start = $urandom_range(0, CELLS - 2 * COLUMNS - 1);
                send_request(OP_SET, 8'($urandom), start);
                seen_nl = 1'b0;
                n = $urandom_range(3, 14);
                repeat (n)
                begin
                    ch = pick_text_char();
                    if (ch == CH_NL)
                    begin
                        if (seen_nl)
                            ch = 8'($urandom_range(32, 126));
                        seen_nl = 1'b1;
                    end
                    send_request(OP_PUT, ch, $urandom_range(0, 2047));
                end
                repeat ($urandom_range(1, 4))
                    send_request(OP_READ, 8'($urandom), start + $urandom_range(0, 24));
            end
            else if (r < 72)
            begin
                // Long line from a row start, up to a full row
                start = COLUMNS * $urandom_range(0, ROWS - 3);
                n = $urandom_range(20, COLUMNS);
                send_request(OP_SET, 8'($urandom), start);
                repeat (n)
                begin
                    if ($urandom_range(0, 9) == 0)
                        ch = 8'($urandom_range(128, 255));
                    else
                        ch = 8'($urandom_range(32, 126));
                    send_request(OP_PUT, ch, $urandom_range(0, 2047));
                end
                repeat (2)
                    send_request(OP_READ, 8'($urandom), start + $urandom_range(0, n - 1));
            end
            else if (r < 82)
            begin
                // Bottom-row text that can scroll; start from an idle unit
                wait_until_idle();
                if ($urandom_range(0, 1) == 0)
                    start = CELLS - $urandom_range(1, 2 * TAB_WIDTH);
                else
                    start = LAST_ROW_START + $urandom_range(0, COLUMNS - 1);
                send_request(OP_SET, 8'($urandom), start);
                repeat ($urandom_range(2, 6))
                    send_request(OP_PUT, pick_text_char(), $urandom_range(0, 2047));
                repeat ($urandom_range(1, 4))
                    send_request(OP_READ, 8'($urandom),
                                 $urandom_range(CELLS - 3 * COLUMNS, 2047));
            end
            else
            begin
                // Raw noise over every field, unused op included
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), 8'($urandom),
                                 $urandom_range(0, 2047));
            end
        end

        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d puts, %0d cursor sets, %0d cell reads, %0d unused ops.",
                 checked_count, put_count, set_count, read_count, other_count);
        $display("Screen scrolled %0d times under random request gaps and result stalls.",
                 scroll_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Timeout with %0d results outstanding", console_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

/* text_console_cursor_scroll_unit.f */
src/tccs_pkg.sv
src/tccs_if.sv
src/tccs_ctrl.sv
src/tccs_dp.sv
src/text_console_cursor_scroll_unit.sv
tb/sv/text_console_cursor_scroll_unit_test.sv
